// ===== rtl/core/erg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erg_pkg
// Shared types, sizes and the control store of the Euclidean rhythm generator.
// ----------------------------------------------------------------------------
package erg_pkg;

  localparam int MAX_STEPS   = 64;
  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = 7;                        // pulse/step count width
  localparam int IDX_W       = 6;                        // step index width
  localparam int LVL_W       = $clog2(MAX_STEPS);        // level store address
  localparam int STK_AW      = $clog2(STACK_DEPTH);      // stack address
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);  // stack fill, 0..depth

  typedef struct packed {
    logic [CNT_W-1:0] pulse_count;
    logic [CNT_W-1:0] step_count;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] step_index;
    logic             hit;
    logic             last;
  } out_word_t;

  // Saved expansion frame: level and next child to visit.
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [CNT_W-1:0] nxt;
  } frame_t;

  // Control store addresses.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DCHK,
    S_DSUB,
    S_DSTORE,
    S_DFIN,
    S_READ,
    S_VISIT,
    S_CHILD,
    S_PUSH,
    S_EMIT,
    S_POP,
    S_POPLD,
    S_FLUSH
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,    // take request, clamp, seed division
    OP_SUB,     // one subtract of the division
    OP_STORE,   // write level count/remainder, swap operands
    OP_FIN,     // write top level count, open root frame
    OP_READ,    // read count/remainder of top frame level
    OP_PUSH,    // save top frame, open child frame; skip child when full
    OP_EMIT,    // emit a rest or hit, advance frame
    OP_POP,     // drop top frame, read saved frame
    OP_POPLD,   // restore saved frame
    OP_FLUSH    // release held word with last marker
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_R_LE1,
    C_DIV_GE_R,
    C_FRAME_DONE,
    C_CHILD_LEAF,
    C_LAST_FRAME
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucw_t;

  // Control store: op, jump condition, jump target. Falls through otherwise.
  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    unique case (s)
      S_IDLE:   w = '{OP_LOAD,  C_NO_IN,      S_IDLE};
      S_DCHK:   w = '{OP_NOP,   C_R_LE1,      S_DFIN};
      S_DSUB:   w = '{OP_SUB,   C_DIV_GE_R,   S_DSUB};
      S_DSTORE: w = '{OP_STORE, C_ALWAYS,     S_DCHK};
      S_DFIN:   w = '{OP_FIN,   C_NEVER,      S_IDLE};
      S_READ:   w = '{OP_READ,  C_NEVER,      S_IDLE};
      S_VISIT:  w = '{OP_NOP,   C_FRAME_DONE, S_POP};
      S_CHILD:  w = '{OP_NOP,   C_CHILD_LEAF, S_EMIT};
      S_PUSH:   w = '{OP_PUSH,  C_ALWAYS,     S_READ};
      S_EMIT:   w = '{OP_EMIT,  C_ALWAYS,     S_VISIT};
      S_POP:    w = '{OP_POP,   C_LAST_FRAME, S_FLUSH};
      S_POPLD:  w = '{OP_POPLD, C_ALWAYS,     S_READ};
      S_FLUSH:  w = '{OP_FLUSH, C_ALWAYS,     S_IDLE};
      default:  w = '{OP_NOP,   C_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/euclidean_rhythm_generator_top.sv =====
`timescale 1ns / 1ps
// Sequence: take a request, then per division level a check, one subtract
//   per quotient unit and a store, then close the division; then emit steps
//   and expand inner frames. The first word leaves once the second step is found.
// Requests: one at a time; a new request is taken only once the previous
//   one is fully expanded and flushed; output stalls hold the walk.
// Reset: synchronous, active low; sequencer idle, output empty, stack empty.
// ----------------------------------------------------------------------------
// euclidean_rhythm_generator_top
// Bjorklund rhythm generator: repeated division into per-level counts and
// remainders, then a stack walk of the levels that emits one word per step.
// ----------------------------------------------------------------------------
module euclidean_rhythm_generator_top
  import erg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // --------------------------------------------------------------------------
  // Sequencer: step counter addressing the control store.
  // --------------------------------------------------------------------------
  step_t pc_r, pc_nxt;
  ucw_t  uw;

  assign uw = ucode(pc_r);

  // Division datapath.
  logic [CNT_W-1:0] div_r;    // running dividend
  logic [CNT_W-1:0] r_r;      // running divisor (current remainder)
  logic [CNT_W-1:0] q_r;      // quotient built by repeated subtraction
  logic [LVL_W-1:0] lvl_r;    // level being produced

  // Level stores and their registered read data.
  logic [CNT_W-1:0] cnt_mem [MAX_STEPS];
  logic [CNT_W-1:0] rem_mem [MAX_STEPS];
  logic [CNT_W-1:0] cnt_rd_r;
  logic [CNT_W-1:0] rem_rd_r;

  // Expansion: top frame lives in registers, the frames below it in memory.
  frame_t           stk_mem [STACK_DEPTH];
  frame_t           stk_rd_r;
  logic [SP_W-1:0]  sp_r, sp_nxt;     // frames on the stack, top included
  logic [LVL_W-1:0] top_lvl_r;
  logic [CNT_W-1:0] top_nxt_r;

  // Emission: one word is held back until we know whether it is the last.
  logic [CNT_W-1:0] n_r;              // words emitted so far
  logic             pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0] pend_idx_r;
  logic             pend_hit_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r;

  // --------------------------------------------------------------------------
  // Request clamping.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] st_clamp, p_clamp;

  always_comb begin
    st_clamp = (in_data.step_count > CNT_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS)
                                                        : in_data.step_count;
    p_clamp  = (in_data.pulse_count > st_clamp) ? st_clamp : in_data.pulse_count;
  end

  // --------------------------------------------------------------------------
  // Frame decode: which child comes next and what it is.
  // Children of level L: count copies of L-1, then L-2 if the remainder is
  // nonzero. Level -1 is a rest, level -2 a hit.
  // --------------------------------------------------------------------------
  logic             use_cnt, frame_done, child_leaf, child_hit;
  logic [LVL_W-1:0] child_lvl;
  logic             emit_ok;

  always_comb begin
    use_cnt    = (top_nxt_r < cnt_rd_r);
    frame_done = ({1'b0, top_nxt_r} >=
                  ({1'b0, cnt_rd_r} + {{CNT_W{1'b0}}, (rem_rd_r != '0)}));
    child_leaf = use_cnt ? (top_lvl_r == '0) : (top_lvl_r <= LVL_W'(1));
    child_hit  = !use_cnt && (top_lvl_r == '0);
    child_lvl  = top_lvl_r - (use_cnt ? LVL_W'(1) : LVL_W'(2));
    emit_ok    = (n_r < CNT_W'(MAX_STEPS));
  end

  // --------------------------------------------------------------------------
  // Output hold: a step that must move the held word waits for a free slot.
  // --------------------------------------------------------------------------
  logic out_free, needs_out, go, move_out, cond_hit;

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    needs_out = pend_vld_r &&
                ((uw.op == OP_FLUSH) || ((uw.op == OP_EMIT) && child_leaf && emit_ok));
    go        = !needs_out || out_free;
    move_out  = go && needs_out;
  end

  always_comb begin
    case (uw.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_NO_IN:      cond_hit = !in_valid || (in_data.step_count == '0);
      C_R_LE1:      cond_hit = (r_r <= CNT_W'(1));
      C_DIV_GE_R:   cond_hit = (div_r >= r_r);
      C_FRAME_DONE: cond_hit = frame_done;
      C_CHILD_LEAF: cond_hit = child_leaf;
      C_LAST_FRAME: cond_hit = (sp_r == SP_W'(1));
      default:      cond_hit = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    if (!go) begin
      pc_nxt = pc_r;
    end else if (cond_hit) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = step_t'(pc_r + 4'd1);
    end
  end

  // Control outputs of each op.
  logic load_go;

  always_comb begin
    load_go       = (uw.op == OP_LOAD) && in_valid && (in_data.step_count != '0);
    sp_nxt        = sp_r;
    pend_vld_nxt  = pend_vld_r;
    out_valid_nxt = move_out ? 1'b1 : (out_valid_r && out_stall);
    if (go) begin
      unique case (uw.op)
        OP_FIN:   sp_nxt = SP_W'(1);
        OP_PUSH:  if (sp_r < SP_W'(STACK_DEPTH)) sp_nxt = sp_r + SP_W'(1);
        OP_POP:   sp_nxt = sp_r - SP_W'(1);
        default:  sp_nxt = sp_r;
      endcase
      if (uw.op == OP_FIN || uw.op == OP_FLUSH) begin
        pend_vld_nxt = 1'b0;
      end else if (uw.op == OP_EMIT && child_leaf && emit_ok) begin
        pend_vld_nxt = 1'b1;
      end
    end
  end

  assign in_stall  = (pc_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      sp_r        <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (move_out) begin
      out_word_r.step_index <= pend_idx_r;
      out_word_r.hit        <= pend_hit_r;
      out_word_r.last       <= (uw.op == OP_FLUSH);
    end
    if (go) begin
      case (uw.op)
        OP_LOAD: begin
          if (load_go) begin
            div_r <= st_clamp - p_clamp;
            r_r   <= p_clamp;
            q_r   <= '0;
            lvl_r <= '0;
          end
        end
        OP_SUB: begin
          if (div_r >= r_r) begin
            div_r <= div_r - r_r;
            q_r   <= q_r + CNT_W'(1);
          end
        end
        OP_STORE: begin
          div_r <= r_r;
          r_r   <= div_r;
          q_r   <= '0;
          lvl_r <= lvl_r + LVL_W'(1);
        end
        OP_FIN: begin
          top_lvl_r <= lvl_r;
          top_nxt_r <= '0;
          n_r       <= '0;
        end
        OP_PUSH: begin
          if (sp_r < SP_W'(STACK_DEPTH)) begin
            top_lvl_r <= child_lvl;
            top_nxt_r <= '0;
          end else begin
            top_nxt_r <= top_nxt_r + CNT_W'(1);
          end
        end
        OP_EMIT: begin
          top_nxt_r <= top_nxt_r + CNT_W'(1);
          if (child_leaf && emit_ok) begin
            pend_idx_r <= n_r[IDX_W-1:0];
            pend_hit_r <= child_hit;
            n_r        <= n_r + CNT_W'(1);
          end
        end
        OP_POPLD: begin
          top_lvl_r <= stk_rd_r.lvl;
          top_nxt_r <= stk_rd_r.nxt;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Level stores: one write and one registered read each.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (go && uw.op == OP_STORE) begin
      cnt_mem[lvl_r] <= q_r;
    end else if (go && uw.op == OP_FIN) begin
      cnt_mem[lvl_r] <= div_r;
    end
    if (go && uw.op == OP_READ) begin
      cnt_rd_r <= cnt_mem[top_lvl_r];
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      rem_mem[LVL_W'(0)] <= p_clamp;
    end else if (go && uw.op == OP_STORE) begin
      rem_mem[lvl_r + LVL_W'(1)] <= div_r;
    end
    if (go && uw.op == OP_READ) begin
      rem_rd_r <= rem_mem[top_lvl_r];
    end
  end

  // Frame stack store.
  logic [SP_W-1:0] sp_m1, sp_m2;

  assign sp_m1 = sp_r - SP_W'(1);
  assign sp_m2 = sp_r - SP_W'(2);

  always_ff @(posedge clk) begin
    if (go && uw.op == OP_PUSH && sp_r < SP_W'(STACK_DEPTH)) begin
      stk_mem[sp_m1[STK_AW-1:0]] <= '{lvl: top_lvl_r, nxt: top_nxt_r + CNT_W'(1)};
    end
    if (go && uw.op == OP_POP) begin
      stk_rd_r <= stk_mem[sp_m2[STK_AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_no_held_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_IDLE) |-> !pend_vld_r)
    else $error("held word left over when idle");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  a_frame_present: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_VISIT || pc_r == S_CHILD || pc_r == S_POP) |-> (sp_r != '0))
    else $error("expansion step with empty stack");

  a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != S_IDLE && pc_r != S_DCHK && pc_r != S_DSUB && pc_r != S_DSTORE &&
     pc_r != S_DFIN) |-> (n_r <= CNT_W'(MAX_STEPS)))
    else $error("more words than steps");

  a_flush_leads_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_FLUSH && go) |=> (pc_r == S_IDLE))
    else $error("flush did not return to idle");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Euclidean rhythm generator. A directed table
// covers the size extremes, clamping, saturation and ignored requests, then
// constrained-by-hand random requests run under four idling profiles. Words
// come from an in-bench Bjorklund predictor or are typed in per row; each
// output word is checked field by field against the oldest expected step.
// ----------------------------------------------------------------------------
module tb_top;
  import erg_pkg::*;

  // No-progress window before the run is declared hung. The longest quiet
  // stretch is the division plus first descent of a request.
  localparam int WATCHDOG_LIMIT = 4000;
  // Tail after the last expected word, to catch stray extra words.
  localparam int DRAIN_CYCLES   = 400;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int NUM_PHASES      = 4;

  // How a directed row gets its expected words.
  typedef enum logic [1:0] {
    ROW_PREDICT,   // run the predictor
    ROW_ALL_REST,  // len rests, typed in
    ROW_ALL_HIT,   // len hits, typed in
    ROW_NONE       // request dropped, no words
  } row_kind_e;

  typedef struct packed {
    logic [CNT_W-1:0] pulses;
    logic [CNT_W-1:0] steps;
    row_kind_e        kind;
    logic [CNT_W-1:0] len;
  } dir_row_t;

  localparam int NUM_DIRECTED = 25;

  // Directed requests: extremes, clamp, saturation, zero-step drops, and a
  // spread of classic rhythms left to the predictor.
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{7'd0,   7'd1,   ROW_ALL_REST, 7'd1},   // smallest pattern, no pulses
    '{7'd1,   7'd1,   ROW_ALL_HIT,  7'd1},   // smallest pattern, one pulse
    '{7'd0,   7'd64,  ROW_ALL_REST, 7'd64},  // longest pattern, all rests
    '{7'd64,  7'd64,  ROW_ALL_HIT,  7'd64},  // longest pattern, all hits
    '{7'd0,   7'd0,   ROW_NONE,     7'd0},   // zero steps, dropped
    '{7'd127, 7'd0,   ROW_NONE,     7'd0},   // zero steps, all-ones pulses
    '{7'd127, 7'd127, ROW_ALL_HIT,  7'd64},  // steps saturate, pulses clamp
    '{7'd0,   7'd127, ROW_ALL_REST, 7'd64},  // steps saturate, no pulses
    '{7'd100, 7'd64,  ROW_ALL_HIT,  7'd64},  // pulses clamp to steps
    '{7'd65,  7'd64,  ROW_ALL_HIT,  7'd64},  // pulses one above steps
    '{7'd127, 7'd1,   ROW_ALL_HIT,  7'd1},   // clamp down to a single step
    '{7'd64,  7'd127, ROW_ALL_HIT,  7'd64},  // saturated steps, full pulses
    '{7'd3,   7'd8,   ROW_PREDICT,  7'd0},
    '{7'd5,   7'd8,   ROW_PREDICT,  7'd0},
    '{7'd5,   7'd13,  ROW_PREDICT,  7'd0},
    '{7'd1,   7'd64,  ROW_PREDICT,  7'd0},   // single pulse, long pattern
    '{7'd63,  7'd64,  ROW_PREDICT,  7'd0},   // single rest, long pattern
    '{7'd32,  7'd64,  ROW_PREDICT,  7'd0},
    '{7'd21,  7'd64,  ROW_PREDICT,  7'd0},   // one division level, remainder 1
    '{7'd2,   7'd3,   ROW_PREDICT,  7'd0},
    '{7'd1,   7'd2,   ROW_PREDICT,  7'd0},
    '{7'd7,   7'd12,  ROW_PREDICT,  7'd0},
    '{7'd13,  7'd24,  ROW_PREDICT,  7'd0},
    '{7'd9,   7'd16,  ROW_PREDICT,  7'd0},
    '{7'd10,  7'd70,  ROW_PREDICT,  7'd0}    // saturated steps, mid pulses
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // Expected step words, oldest first.
  out_word_t expected_steps [$];
  int        mismatch_count  = 0;
  int        stalled_cycles  = 0;
  int        send_idle_pct   = 0;
  int        recv_stall_pct  = 0;

  euclidean_rhythm_generator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Append one expected word at the tail of the queue.
  function automatic void queue_expected(input out_word_t w);
    expected_steps = {expected_steps, w};
  endfunction

  // Bjorklund expansion of one request into its step words. Levels are
  // built by repeated division, then walked with a bounded frame stack:
  // a frame at level L visits count[L] children at L-1, then one at L-2
  // when the remainder is nonzero. Level -1 is a rest, below that a hit.
  function automatic void predict_rhythm(input in_word_t w);
    logic [CNT_W-1:0] pulses;
    logic [CNT_W-1:0] steps;
    logic [CNT_W-1:0] divisor;
    logic [CNT_W-1:0] r;
    logic [CNT_W-1:0] counts [0:MAX_STEPS];
    logic [CNT_W-1:0] rems   [0:MAX_STEPS];
    int               frame_lvl  [0:STACK_DEPTH-1];
    int               frame_next [0:STACK_DEPTH-1];
    out_word_t        pattern    [0:MAX_STEPS-1];
    int               sp;
    int               lvl;
    int               top_lvl;
    int               cnt;
    int               total;
    int               child;
    int               emitted;
    pulses  = w.pulse_count;
    steps   = w.step_count;
    emitted = 0;
    if (steps == 0) return;
    if (steps > MAX_STEPS) steps = CNT_W'(MAX_STEPS);
    if (pulses > steps) pulses = steps;

    divisor = steps - pulses;
    rems[0] = pulses;
    lvl     = 0;
    while (rems[lvl] > 1 && lvl < MAX_STEPS) begin
      r              = rems[lvl];
      counts[lvl]    = divisor / r;
      rems[lvl + 1]  = divisor % r;
      divisor        = r;
      lvl++;
    end
    counts[lvl] = divisor;

    frame_lvl[0]  = lvl;
    frame_next[0] = 0;
    sp            = 1;
    while (sp > 0) begin
      top_lvl = frame_lvl[sp - 1] & 63;
      cnt     = int'(counts[top_lvl]);
      total   = cnt + ((rems[top_lvl] != 0) ? 1 : 0);
      if (frame_next[sp - 1] >= total) begin
        sp--;
        continue;
      end
      child = (frame_next[sp - 1] < cnt) ? frame_lvl[sp - 1] - 1 : frame_lvl[sp - 1] - 2;
      frame_next[sp - 1]++;
      if (child < 0) begin
        if (emitted < MAX_STEPS) begin
          pattern[emitted].step_index = emitted[IDX_W-1:0];
          pattern[emitted].hit        = (child < -1);
          pattern[emitted].last       = 1'b0;
          emitted++;
        end
      end else if (sp < STACK_DEPTH) begin
        frame_lvl[sp]  = child;
        frame_next[sp] = 0;
        sp++;
      end
    end

    if (emitted > 0) pattern[emitted - 1].last = 1'b1;
    for (int i = 0; i < emitted; i++) queue_expected(pattern[i]);
  endfunction

  // Drive one request word, hold it until taken, then queue its steps.
  task automatic send_request(input in_word_t w, input row_kind_e kind, input int len);
    out_word_t typed;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    // Taken at this edge.
    if (kind == ROW_PREDICT) begin
      predict_rhythm(w);
    end else if (kind != ROW_NONE) begin
      for (int i = 0; i < len; i++) begin
        typed.step_index = i[IDX_W-1:0];
        typed.hit        = (kind == ROW_ALL_HIT);
        typed.last       = (i == len - 1);
        queue_expected(typed);
      end
    end
  endtask

  // Mostly well-formed sizes, small ones favored; the rest exercises the
  // clamp, the saturation and the zero-step drop.
  function automatic in_word_t random_request();
    in_word_t w;
    int       sel;
    int       steps;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      steps         = $urandom_range(1, (sel < 50) ? 16 : 64);
      w.step_count  = steps[CNT_W-1:0];
      w.pulse_count = CNT_W'($urandom_range(0, steps));
    end else if (sel < 90) begin
      w.step_count  = CNT_W'($urandom_range(1, 64));
      w.pulse_count = CNT_W'($urandom_range(0, 127));
    end else if (sel < 95) begin
      w.step_count  = CNT_W'($urandom_range(65, 127));
      w.pulse_count = CNT_W'($urandom_range(0, 127));
    end else begin
      w.step_count  = '0;
      w.pulse_count = CNT_W'($urandom_range(0, 127));
    end
    return w;
  endfunction

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Output checker: each taken word against the oldest expected step.
  always @(posedge clk) begin : step_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        report_mismatch($sformatf("unexpected word idx=%0d hit=%0d last=%0d",
                                  out_data.step_index, out_data.hit, out_data.last));
      end else begin
        want = expected_steps.pop_front();
        if (out_data.step_index !== want.step_index)
          report_mismatch($sformatf("step_index expected %0d got %0d",
                                    want.step_index, out_data.step_index));
        if (out_data.hit !== want.hit)
          report_mismatch($sformatf("hit at step %0d expected %0d got %0d",
                                    want.step_index, want.hit, out_data.hit));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last at step %0d expected %0d got %0d",
                                    want.step_index, want.last, out_data.last));
      end
    end
  end

  // Watchdog: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      stalled_cycles = 0;
    else
      stalled_cycles = stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : main_seq
    in_word_t w;
    int       sent;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling on either side.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      w.pulse_count = DIRECTED[i].pulses;
      w.step_count  = DIRECTED[i].steps;
      send_request(w, DIRECTED[i].kind, int'(DIRECTED[i].len));
    end

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        w = random_request();
        send_request(w, ROW_PREDICT, 0);
        // Dropped requests do not count toward the phase.
        if (w.step_count != 0) sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain; the watchdog covers a missing word.
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
